// File: hdl/hysteresis_edge_period_meter_defines.svh
// Assertion macros shared by the checker of the edge period meter.
`ifndef HYSTERESIS_EDGE_PERIOD_METER_DEFINES_SVH
`define HYSTERESIS_EDGE_PERIOD_METER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define HEPM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hepm assertion failed");

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define HEPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hepm assertion failed");

`endif

// File: hdl/hepm_pkg.sv
// Types and constants of the hysteresis edge period meter.
package hepm_pkg;

  // Fixed field and register widths.
  localparam int SAMPLE_W   = 10;
  localparam int THR_W      = 10;
  localparam int MINRUN_W   = 8;
  localparam int PERIOD_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RISE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FALL = 2'd3;

  // Register reset values.
  localparam logic [THR_W-1:0]    LOW_THR_RST  = 10'd512;
  localparam logic [THR_W-1:0]    HIGH_THR_RST = 10'd716;
  localparam logic [MINRUN_W-1:0] MIN_RUN_RST  = 8'd5;

  // Operating phase of the meter.
  typedef enum logic [2:0] {
    PH_WAIT  = 3'b001,
    PH_START = 3'b010,
    PH_RUN   = 3'b100
  } phase_e;

  // Classification of one sample.
  typedef struct packed {
    logic clean;
    logic level;
  } cls_t;

endpackage

// File: hdl/hepm_ifs.sv
// Stream interfaces for the sample input and the period output.
interface hepm_sample_if;
  logic                          valid;
  logic                          ready;
  logic [hepm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface hepm_period_if;
  logic                          valid;
  logic                          ready;
  logic [hepm_pkg::PERIOD_W-1:0] period_ticks;

  modport source (output valid, output period_ticks, input ready);
  modport sink (input valid, input period_ticks, output ready);
endinterface

// File: hdl/hepm_classify.sv
// Threshold classifier: high, low or dead band for one sample.
module hepm_classify (
  input  logic [hepm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [hepm_pkg::THR_W-1:0]    low_thr_i,
  input  logic [hepm_pkg::THR_W-1:0]    high_thr_i,
  output hepm_pkg::cls_t                cls_o
);

  // The high test wins when the thresholds are crossed.
  always_comb begin
    cls_o.clean = 1'b1;
    cls_o.level = 1'b0;
    if (sample_i > high_thr_i) begin
      cls_o.level = 1'b1;
    end else if (sample_i < low_thr_i) begin
      cls_o.level = 1'b0;
    end else begin
      cls_o.clean = 1'b0;
    end
  end

endmodule

// File: hdl/hysteresis_edge_period_meter.sv
// Top level of the hysteresis edge period meter.
// A period result passes from the sample register, loaded when its sample request is
// accepted, to the result register; a held result can stall it between the two.
// Throughput: one sample request per cycle; ready drops only while a held result stalls.
// The path between the two registers holds the two threshold compares and the tick subtract.
// Reset clears the phase, run state, tick counters and the output valid, and loads
// the register defaults (thresholds 512 and 716, run lengths 5).
module hysteresis_edge_period_meter #(
  parameter int MAX_RUN   = 255,
  parameter int TICK_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hepm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hepm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  hepm_sample_if.sink                     smp_i,
  hepm_period_if.source                   per_o
);

  localparam int RUN_W = $clog2(MAX_RUN + 1);
  localparam int NW    = (RUN_W > hepm_pkg::MINRUN_W) ? RUN_W : hepm_pkg::MINRUN_W;

  // Configuration registers.
  logic [hepm_pkg::THR_W-1:0]    low_thr_q, high_thr_q;
  logic [hepm_pkg::MINRUN_W-1:0] rise_len_q, fall_len_q;

  // Sample register and result register.
  logic                          s1_valid_q;
  logic [hepm_pkg::SAMPLE_W-1:0] s1_sample_q;
  logic                          out_valid_q, out_valid_d;
  logic [hepm_pkg::PERIOD_W-1:0] period_q, period_d;

  // Meter state.
  hepm_pkg::phase_e     phase_q, phase_d;
  logic                 acc_lvl_q, acc_lvl_d;
  logic                 last_lvl_q, last_lvl_d;
  logic                 run_lvl_q, run_lvl_d;
  logic [RUN_W-1:0]     run_len_q, run_len_d;
  logic                 prev_db_q, prev_db_d;
  logic [TICK_BITS-1:0] run_edge_q, run_edge_d;
  logic [TICK_BITS-1:0] tick_q, tick_d;
  logic [TICK_BITS-1:0] last_edge_q, last_edge_d;

  hepm_pkg::cls_t          cls;
  logic                    out_free;
  logic                    advance;
  logic                    level;
  logic                    changed;
  logic [TICK_BITS-1:0]    period;
  logic [TICK_BITS+31:0]   period_ext;

  // Required run length, clamped to 1..MAX_RUN.
  function automatic logic [NW-1:0] need_f(logic [hepm_pkg::MINRUN_W-1:0] r);
    logic [NW-1:0] rx;
    rx = NW'(r);
    if (r == '0) begin
      return NW'(1);
    end
    if (rx > NW'(MAX_RUN)) begin
      return NW'(MAX_RUN);
    end
    return rx;
  endfunction

  hepm_classify u_classify (
    .sample_i   (s1_sample_q),
    .low_thr_i  (low_thr_q),
    .high_thr_i (high_thr_q),
    .cls_o      (cls)
  );

  // Handshake: the sample stage moves on whenever the result register can take data.
  assign out_free    = !out_valid_q || per_o.ready;
  assign advance     = s1_valid_q && out_free;
  assign smp_i.ready = !s1_valid_q || out_free;

  assign per_o.valid        = out_valid_q;
  assign per_o.period_ticks = period_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= hepm_pkg::LOW_THR_RST;
      high_thr_q <= hepm_pkg::HIGH_THR_RST;
      rise_len_q <= hepm_pkg::MIN_RUN_RST;
      fall_len_q <= hepm_pkg::MIN_RUN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hepm_pkg::CFG_LOW_THR:  low_thr_q  <= cfg_wdata_i[hepm_pkg::THR_W-1:0];
        hepm_pkg::CFG_HIGH_THR: high_thr_q <= cfg_wdata_i[hepm_pkg::THR_W-1:0];
        hepm_pkg::CFG_MIN_RISE: rise_len_q <= cfg_wdata_i[hepm_pkg::MINRUN_W-1:0];
        hepm_pkg::CFG_MIN_FALL: fall_len_q <= cfg_wdata_i[hepm_pkg::MINRUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (smp_i.ready) begin
      s1_valid_q <= smp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_i.valid && smp_i.ready) begin
      s1_sample_q <= smp_i.sample;
    end
  end

  assign level      = cls.clean ? cls.level : last_lvl_q;
  assign period     = run_edge_d - last_edge_q;
  assign period_ext = {32'd0, period};

  // Run tracking, level acceptance and falling-edge period.
  always_comb begin
    phase_d     = phase_q;
    acc_lvl_d   = acc_lvl_q;
    last_lvl_d  = last_lvl_q;
    run_lvl_d   = run_lvl_q;
    run_len_d   = run_len_q;
    prev_db_d   = prev_db_q;
    run_edge_d  = run_edge_q;
    tick_d      = tick_q;
    last_edge_d = last_edge_q;
    out_valid_d = out_valid_q && !per_o.ready;
    period_d    = period_q;
    changed     = (level != run_lvl_q);

    if (advance) begin
      tick_d    = tick_q + TICK_BITS'(1);
      prev_db_d = !cls.clean;
      if (phase_q == hepm_pkg::PH_WAIT) begin
        if (cls.clean) begin
          last_lvl_d = level;
          run_lvl_d  = level;
          run_len_d  = RUN_W'(1);
          run_edge_d = tick_q;
          phase_d    = hepm_pkg::PH_START;
        end
      end else begin
        if (!changed) begin
          if (run_len_q < RUN_W'(MAX_RUN)) begin
            run_len_d = run_len_q + RUN_W'(1);
          end
        end else begin
          run_lvl_d  = level;
          run_len_d  = RUN_W'(1);
          run_edge_d = prev_db_q ? (tick_q - TICK_BITS'(1)) : tick_q;
        end
        last_lvl_d = level;

        case (phase_q)
          hepm_pkg::PH_START: begin
            // Current run first, then the run it just ended.
            if (NW'(run_len_d) >= need_f(run_lvl_d ? rise_len_q : fall_len_q)) begin
              acc_lvl_d   = run_lvl_d;
              phase_d     = hepm_pkg::PH_RUN;
              last_edge_d = tick_q;
            end else if (changed &&
                NW'(run_len_q) >= need_f(run_lvl_q ? rise_len_q : fall_len_q)) begin
              acc_lvl_d   = run_lvl_q;
              phase_d     = hepm_pkg::PH_RUN;
              last_edge_d = tick_q;
            end
          end
          default: begin
            if (run_lvl_d != acc_lvl_q &&
                NW'(run_len_d) == need_f(run_lvl_d ? rise_len_q : fall_len_q)) begin
              if (acc_lvl_q) begin
                out_valid_d = 1'b1;
                period_d    = period_ext[hepm_pkg::PERIOD_W-1:0];
                last_edge_d = run_edge_d;
                acc_lvl_d   = 1'b0;
              end else begin
                acc_lvl_d   = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hepm_pkg::PH_WAIT;
      acc_lvl_q   <= 1'b0;
      last_lvl_q  <= 1'b0;
      run_lvl_q   <= 1'b0;
      run_len_q   <= '0;
      prev_db_q   <= 1'b0;
      run_edge_q  <= '0;
      tick_q      <= '0;
      last_edge_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_lvl_q   <= acc_lvl_d;
      last_lvl_q  <= last_lvl_d;
      run_lvl_q   <= run_lvl_d;
      run_len_q   <= run_len_d;
      prev_db_q   <= prev_db_d;
      run_edge_q  <= run_edge_d;
      tick_q      <= tick_d;
      last_edge_q <= last_edge_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    period_q <= period_d;
  end

endmodule

// File: hdl/hepm_checker.sv
// Port-level checker for the edge period meter, bound to the top level.
`include "hysteresis_edge_period_meter_defines.svh"

module hepm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [hepm_pkg::PERIOD_W-1:0] out_period_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled result keeps its value.
  `HEPM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_period_i))

  // A result in an empty output follows a sample request accepted into the sample register.
  `HEPM_ASSERT_IMPLY(a_out_cause, out_valid_i && !$past(in_acc, 2) && !$past(out_valid_i), 1'b0)

  // With no result waiting, the input side is always open.
  `HEPM_ASSERT_IMPLY(a_in_open, !out_valid_i, in_ready_i)

  // Once a result is taken, a request can enter in that same cycle.
  `HEPM_ASSERT_IMPLY(a_in_flow, out_valid_i && out_ready_i, in_ready_i)

endmodule

bind hysteresis_edge_period_meter hepm_checker u_hepm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (smp_i.valid),
  .in_ready_i   (smp_i.ready),
  .out_valid_i  (per_o.valid),
  .out_ready_i  (per_o.ready),
  .out_period_i (per_o.period_ticks)
);

// File: bench/hysteresis_edge_period_meter_tb.sv
// Self-checking testbench of the hysteresis edge period meter: stream stimulus against a predictor.
module hysteresis_edge_period_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUN     = 255;
  localparam int SMP_W       = hepm_pkg::SAMPLE_W;
  localparam int RUN_CFG_W   = hepm_pkg::MINRUN_W;
  localparam int CODE_MAX    = (1 << hepm_pkg::SAMPLE_W) - 1;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  // Coarse classes of codes the stimulus generator aims for.
  typedef enum int {
    Z_LOW,
    Z_HIGH,
    Z_DEAD,
    Z_ANY
  } zone_e;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [hepm_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [hepm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            smp_valid = 1'b0;
  logic [hepm_pkg::SAMPLE_W-1:0]   smp_code = '0;
  logic                            per_ready = 1'b0;

  hepm_sample_if smp_if ();
  hepm_period_if per_if ();

  assign smp_if.valid  = smp_valid;
  assign smp_if.sample = smp_code;
  assign per_if.ready  = per_ready;

  hysteresis_edge_period_meter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .smp_i       (smp_if),
    .per_o       (per_if)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies seen by the predictor.
  logic [hepm_pkg::THR_W-1:0]    low_thr  = hepm_pkg::LOW_THR_RST;
  logic [hepm_pkg::THR_W-1:0]    high_thr = hepm_pkg::HIGH_THR_RST;
  logic [hepm_pkg::MINRUN_W-1:0] rise_cfg = hepm_pkg::MIN_RUN_RST;
  logic [hepm_pkg::MINRUN_W-1:0] fall_cfg = hepm_pkg::MIN_RUN_RST;

  // Predictor state.
  hepm_pkg::phase_e              mtr_phase = hepm_pkg::PH_WAIT;
  logic                          acc_level = 1'b0;
  logic                          meas_level = 1'b0;
  logic                          run_level = 1'b0;
  logic [7:0]                    run_len = '0;
  logic                          prev_dead = 1'b0;
  logic [hepm_pkg::PERIOD_W-1:0] run_edge = '0;
  logic [hepm_pkg::PERIOD_W-1:0] tick_cnt = '0;
  logic [hepm_pkg::PERIOD_W-1:0] last_edge = '0;

  logic [hepm_pkg::SAMPLE_W-1:0] sample_q[$];
  logic [hepm_pkg::PERIOD_W-1:0] period_q[$];
  int                            n_pushed = 0;
  int                            n_taken = 0;
  int                            n_fail = 0;

  // Handshake bookkeeping of the clocked processes, some of it shared between them.
  bit smp_taken = 1'b0;
  bit res_taken = 1'b0;
  bit busy = 1'b0;
  bit rx_hold_req = 1'b0;
  int tx_wait = 0;
  int rx_wait = 0;
  int rx_hold = 0;
  int tx_gap_max = 10;
  int rx_gap_max = 10;
  int stall_cycles = 0;

  int unsigned head_seq[6] = '{600, 512, 716, 0, 511, 100};
  int unsigned tail_seq[20] = '{1023, 800, 717, 600, 900, 1023, 716, 0, 511, 1023,
                                1023, 1023, 1023, 1023, 512, 700, 255, 128, 3, 1020};

  // Run length that accepts a change to the given level, with clamping.
  function automatic logic [hepm_pkg::MINRUN_W-1:0] run_needed(input logic lvl);
    logic [hepm_pkg::MINRUN_W-1:0] v;
    v = lvl ? rise_cfg : fall_cfg;
    if (v == 0) v = 1;
    if (int'(v) > MAX_RUN) v = RUN_CFG_W'(MAX_RUN);
    return v;
  endfunction

  // Advance the predictor by one accepted sample and queue any period it reports.
  task automatic predict_period(input logic [hepm_pkg::SAMPLE_W-1:0] code);
    logic                          clean;
    logic                          lvl;
    logic                          changed;
    logic                          prior_level;
    logic [7:0]                    prior_len;
    logic [hepm_pkg::PERIOD_W-1:0] t;
    t        = tick_cnt;
    tick_cnt = tick_cnt + 1;
    clean    = 1'b1;
    if (code > high_thr) begin
      lvl = 1'b1;
    end else if (code < low_thr) begin
      lvl = 1'b0;
    end else begin
      clean = 1'b0;
      lvl   = meas_level;
    end

    if (mtr_phase == hepm_pkg::PH_WAIT) begin
      // Dead-band samples are skipped until the first clean one.
      if (clean) begin
        meas_level = lvl;
        run_level  = lvl;
        run_len    = 1;
        run_edge   = t;
        mtr_phase  = hepm_pkg::PH_START;
      end
      prev_dead = !clean;
    end else begin
      changed     = (lvl != run_level);
      prior_level = run_level;
      prior_len   = run_len;
      if (!changed) begin
        if (int'(run_len) < MAX_RUN) run_len = run_len + 1;
      end else begin
        run_level = lvl;
        run_len   = 1;
        run_edge  = prev_dead ? t - 1 : t;
      end
      meas_level = lvl;
      prev_dead  = !clean;

      if (mtr_phase == hepm_pkg::PH_START) begin
        // The current run is tested first, then the run it just ended.
        if (run_len >= run_needed(run_level)) begin
          acc_level = run_level;
          mtr_phase = hepm_pkg::PH_RUN;
          last_edge = t;
        end else if (changed && prior_len >= run_needed(prior_level)) begin
          acc_level = prior_level;
          mtr_phase = hepm_pkg::PH_RUN;
          last_edge = t;
        end
      end else if (run_level != acc_level && run_len == run_needed(run_level)) begin
        if (acc_level) begin
          period_q.push_back(run_edge - last_edge);
          last_edge = run_edge;
          acc_level = 1'b0;
        end else begin
          acc_level = 1'b1;
        end
      end
    end
  endtask

  // Pick a code that lands in the wanted class under the current thresholds, or any code if that class is empty.
  function automatic logic [hepm_pkg::SAMPLE_W-1:0] pick_code(input zone_e z);
    int lo;
    int hi;
    lo = 0;
    hi = -1;
    case (z)
      Z_LOW: begin
        hi = int'(low_thr) - 1;
        if (hi > int'(high_thr)) hi = int'(high_thr);
      end
      Z_HIGH: begin
        lo = int'(high_thr) + 1;
        hi = CODE_MAX;
      end
      Z_DEAD: begin
        lo = int'(low_thr);
        hi = int'(high_thr);
      end
      default: ;
    endcase
    if (hi < lo) return SMP_W'($urandom_range(CODE_MAX, 0));
    return SMP_W'($urandom_range(hi, lo));
  endfunction

  task automatic push_sample(input logic [hepm_pkg::SAMPLE_W-1:0] code);
    sample_q.push_back(code);
    n_pushed++;
  endtask

  // Mostly level runs near the accepting length, some noise and dead-band bursts.
  task automatic gen_traffic(input int n);
    int   left;
    int   len;
    int   k;
    logic lvl;
    left = n;
    lvl  = 1'($urandom_range(0, 1));
    while (left > 0) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        len = $urandom_range(1, 6);
      end else if (k == 1) begin
        len = $urandom_range(1, 3);
      end else begin
        len = int'(run_needed(lvl)) - 1 + $urandom_range(0, 4);
        if ($urandom_range(0, 7) == 0) len = len + $urandom_range(0, 30);
        if (len < 1) len = 1;
      end
      // The last burst is cut so the section sends exactly n requests.
      if (len > left) len = left;
      if (k == 0) begin
        repeat (len) push_sample(pick_code(Z_ANY));
      end else if (k == 1) begin
        repeat (len) push_sample(pick_code(Z_DEAD));
      end else begin
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) push_sample(pick_code(Z_DEAD));
          else push_sample(pick_code(lvl ? Z_HIGH : Z_LOW));
        end
        lvl = !lvl;
      end
      left = left - len;
    end
  endtask

  // Wait until every request is taken and every period has come, then let the pipe drain.
  task automatic wait_idle();
    while (n_taken != n_pushed || period_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write, mirrored into the predictor's copy when it lands.
  task automatic write_reg(input logic [hepm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hepm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      hepm_pkg::CFG_LOW_THR:  low_thr  = data[hepm_pkg::THR_W-1:0];
      hepm_pkg::CFG_HIGH_THR: high_thr = data[hepm_pkg::THR_W-1:0];
      hepm_pkg::CFG_MIN_RISE: rise_cfg = data[hepm_pkg::MINRUN_W-1:0];
      hepm_pkg::CFG_MIN_FALL: fall_cfg = data[hepm_pkg::MINRUN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [hepm_pkg::CFG_DATA_W-1:0] lo,
                           input logic [hepm_pkg::CFG_DATA_W-1:0] hi,
                           input logic [hepm_pkg::CFG_DATA_W-1:0] rise,
                           input logic [hepm_pkg::CFG_DATA_W-1:0] fall);
    write_reg(hepm_pkg::CFG_LOW_THR, lo);
    write_reg(hepm_pkg::CFG_HIGH_THR, hi);
    write_reg(hepm_pkg::CFG_MIN_RISE, rise);
    write_reg(hepm_pkg::CFG_MIN_FALL, fall);
  endtask

  // Sample driver: offers the next pending request after a random gap.
  always @(negedge clk_i) begin
    if (smp_taken) begin
      smp_taken = 1'b0;
      busy      = 1'b0;
      tx_wait   = $urandom_range(0, tx_gap_max);
    end else if (!busy && tx_wait > 0) begin
      tx_wait--;
    end
    if (rst_ni && !busy && tx_wait == 0 && sample_q.size() != 0) begin
      smp_code <= sample_q.pop_front();
      busy = 1'b1;
    end
    smp_valid <= busy;
  end

  // Period receiver: random stall after each result, plus a requested long hold-off.
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold     = HOLD_CYCLES;
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    if (res_taken) begin
      res_taken = 1'b0;
      rx_wait   = $urandom_range(0, rx_gap_max);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    per_ready <= rst_ni && rx_wait == 0 && rx_hold == 0;
  end

  // Monitor: predict on each accepted sample, check each accepted period.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (smp_if.valid && smp_if.ready) begin
        predict_period(smp_if.sample);
        n_taken++;
        smp_taken = 1'b1;
      end
      if (per_if.valid && per_if.ready) begin
        res_taken = 1'b1;
        if (period_q.size() == 0) begin
          $error("period_ticks: no result expected, got %0d", per_if.period_ticks);
          n_fail++;
        end else begin
          if (per_if.period_ticks !== period_q[0]) begin
            $error("period_ticks: expected %0d, got %0d", period_q[0], per_if.period_ticks);
            n_fail++;
          end
          void'(period_q.pop_front());
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if (!rst_ni || (smp_if.valid && smp_if.ready) || (per_if.valid && per_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: dead band at start-up, boundary codes, then a short low run.
    foreach (head_seq[i]) push_sample(SMP_W'(head_seq[i]));
    wait_idle();
    // Shorten the fall run mid start-up so the ended low run decides the level.
    write_reg(hepm_pkg::CFG_MIN_FALL, 10'h302);
    // Rise, edges after dead-band samples, and the extreme codes.
    foreach (tail_seq[i]) push_sample(SMP_W'(tail_seq[i]));
    wait_idle();

    // Short runs while the receiver holds off and the input backs up.
    write_all(10'd300, 10'd700, 10'd3, 10'd2);
    @(posedge clk_i);
    rx_hold_req = 1'b1;
    gen_traffic(150);
    wait_idle();

    // Thresholds at the extremes: every code lies in the dead band.
    write_reg(hepm_pkg::CFG_LOW_THR, 10'd0);
    write_reg(hepm_pkg::CFG_HIGH_THR, 10'd1023);
    gen_traffic(15);
    wait_idle();

    // Crossed thresholds and zero run lengths.
    write_all(10'd1023, 10'd0, 10'd0, 10'h300);
    gen_traffic(80);
    wait_idle();

    // Longest runs, with saturation, and no idling on either side.
    tx_gap_max = 0;
    rx_gap_max = 0;
    write_all(10'd200, 10'd800, 10'h3FF, 10'd255);
    gen_traffic(440);
    wait_idle();

    // Uneven run lengths; the sender pauses halfway until every period has come.
    tx_gap_max = 10;
    rx_gap_max = 10;
    write_all(10'd512, 10'd716, 10'd10, 10'd3);
    gen_traffic(60);
    wait_idle();
    gen_traffic(60);
    wait_idle();

    tx_gap_max = 3;
    write_all(10'd400, 10'd600, 10'd1, 10'd8);
    gen_traffic(120);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
